[rtl/dfr_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
package dfr_pkg;

    // Input beat: one byte of the received buffer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } dfr_in_t;

    // Output beat: one result.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       is_close;
        logic       last;
    } dfr_out_t;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_TRUNC   = 2'd2;

    // Parser phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    // Header field constants
    localparam logic [3:0] OPCODE_CLOSE = 4'h8;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [2:0] HC_EXT16     = 3'd1;
    localparam logic [2:0] HC_EXT64     = 3'd7;
    localparam logic [2:0] HC_MASK      = 3'd3;

    // Work queue between parser and emitter
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified input byte: an optional payload result then an optional status.
    typedef struct packed {
        logic       pay_valid;
        logic [7:0] pay_byte;
        logic       st_valid;
        logic [1:0] st_kind;
        logic       st_close;
    } dfr_entry_t;

endpackage

[rtl/websocket_frame_deframer_top.sv]
// Top level of the WebSocket frame deframer: parser, work queue and emitter.
//
//  Channel | Direction | Handshake            | Beat
//  --------+-----------+----------------------+---------------------------------------
//  in      | input     | in_valid / in_ready  | dfr_in_t  {data_byte, end_of_buffer}
//  out     | output    | out_valid / out_ready| dfr_out_t {kind, payload_byte, is_close, last}
//
//  Flow: the parser takes one byte per cycle while the queue is not full; a byte's
//    first result is written to a queue entry and then to the output register, and
//    a byte giving payload plus status yields two output beats from one entry.
//  Stalls: the 4-entry queue lets the parser keep taking bytes while the output
//    is held; in_ready drops only when the queue is full.
//  Reset: rst_n clears parser state, queue pointers and output valid at once.
module websocket_frame_deframer_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dfr_pkg::dfr_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dfr_pkg::dfr_out_t out_data
);

    // parser -> queue
    logic                q_push;
    logic                q_full;
    dfr_pkg::dfr_entry_t q_push_entry;

    // queue -> emitter
    logic                q_pop;
    logic                q_head_valid;
    dfr_pkg::dfr_entry_t q_head_entry;

    // Front: header fields, length counter, mask key and unmasking
    dfr_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    // Decoupling queue; one entry per byte that yields any result
    dfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    // Back: one or two output beats per entry, last flag on the final one
    dfr_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

[rtl/dfr_parse.sv]
// Header parser and payload unmasker: turns each input byte that yields a result into a queue entry.
module dfr_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dfr_pkg::dfr_in_t    in_data,
    input  logic                q_full,
    output logic                q_push,
    output dfr_pkg::dfr_entry_t q_entry
);

    logic [2:0]  phase_reg,        phase_next;
    logic [3:0]  opcode_reg,       opcode_next;
    logic        masked_reg,       masked_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [63:0] remaining_reg,    remaining_next;
    logic [31:0] mask_key_reg,     mask_key_next;
    logic [1:0]  mask_index_reg,   mask_index_next;

    logic [7:0] b;
    logic [7:0] key;
    logic       len_done;
    logic       complete;
    logic       trunc;
    logic       pay_valid;
    logic       accept;

    assign b        = in_data.data_byte;
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        key = 8'h00;
        if (masked_reg)
        begin
            case (mask_index_reg)
                2'd0:    key = mask_key_reg[31:24];
                2'd1:    key = mask_key_reg[23:16];
                2'd2:    key = mask_key_reg[15:8];
                default: key = mask_key_reg[7:0];
            endcase
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        opcode_next       = opcode_reg;
        masked_next       = masked_reg;
        header_count_next = header_count_reg;
        remaining_next    = remaining_reg;
        mask_key_next     = mask_key_reg;
        mask_index_next   = mask_index_reg;
        len_done          = 1'b0;
        complete          = 1'b0;
        pay_valid         = 1'b0;
        trunc             = 1'b0;

        case (phase_reg)
            dfr_pkg::PH_HDR0:
            begin
                opcode_next = b[3:0];
                phase_next  = dfr_pkg::PH_HDR1;
            end
            dfr_pkg::PH_HDR1:
            begin
                masked_next    = b[7];
                remaining_next = 64'd0;
                if (b[6:0] == dfr_pkg::LEN_EXT16)
                begin
                    header_count_next = dfr_pkg::HC_EXT16;
                    phase_next        = dfr_pkg::PH_EXTLEN;
                end
                else if (b[6:0] == dfr_pkg::LEN_EXT64)
                begin
                    header_count_next = dfr_pkg::HC_EXT64;
                    phase_next        = dfr_pkg::PH_EXTLEN;
                end
                else
                begin
                    remaining_next = {57'd0, b[6:0]};
                    len_done       = 1'b1;
                end
            end
            dfr_pkg::PH_EXTLEN:
            begin
                remaining_next = {remaining_reg[55:0], b};
                if (header_count_reg == 3'd0)
                    len_done = 1'b1;
                else
                    header_count_next = header_count_reg - 3'd1;
            end
            dfr_pkg::PH_MASK:
            begin
                mask_key_next = {mask_key_reg[23:0], b};
                if (header_count_reg == 3'd0)
                begin
                    mask_index_next = 2'd0;
                    if (remaining_reg == 64'd0)
                    begin
                        phase_next = dfr_pkg::PH_DONE;
                        complete   = 1'b1;
                    end
                    else
                        phase_next = dfr_pkg::PH_PAYLOAD;
                end
                else
                    header_count_next = header_count_reg - 3'd1;
            end
            dfr_pkg::PH_PAYLOAD:
            begin
                pay_valid       = 1'b1;
                mask_index_next = mask_index_reg + 2'd1;
                remaining_next  = remaining_reg - 64'd1;
                if (remaining_reg == 64'd1)
                begin
                    phase_next = dfr_pkg::PH_DONE;
                    complete   = 1'b1;
                end
            end
            default:
                phase_next = dfr_pkg::PH_DONE;
        endcase

        // length known: mask capture, payload, or done at once
        if (len_done)
        begin
            if (masked_next)
            begin
                header_count_next = dfr_pkg::HC_MASK;
                mask_key_next     = 32'd0;
                phase_next        = dfr_pkg::PH_MASK;
            end
            else if (remaining_next == 64'd0)
            begin
                phase_next = dfr_pkg::PH_DONE;
                complete   = 1'b1;
            end
            else
                phase_next = dfr_pkg::PH_PAYLOAD;
        end

        if (in_data.end_of_buffer)
        begin
            trunc             = (phase_next != dfr_pkg::PH_DONE);
            phase_next        = dfr_pkg::PH_HDR0;
            opcode_next       = 4'd0;
            masked_next       = 1'b0;
            header_count_next = 3'd0;
            remaining_next    = 64'd0;
            mask_key_next     = 32'd0;
            mask_index_next   = 2'd0;
        end
    end

    always_comb
    begin
        q_entry.pay_valid = pay_valid;
        q_entry.pay_byte  = b ^ key;
        q_entry.st_valid  = complete || trunc;
        q_entry.st_kind   = complete ? dfr_pkg::KIND_GOOD : dfr_pkg::KIND_TRUNC;
        q_entry.st_close  = complete && (opcode_reg == dfr_pkg::OPCODE_CLOSE);
    end

    // bytes with no result (header, trailing) never enter the queue
    assign q_push = accept && (pay_valid || complete || trunc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= dfr_pkg::PH_HDR0;
            opcode_reg       <= 4'd0;
            masked_reg       <= 1'b0;
            header_count_reg <= 3'd0;
            remaining_reg    <= 64'd0;
            mask_key_reg     <= 32'd0;
            mask_index_reg   <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            opcode_reg       <= opcode_next;
            masked_reg       <= masked_next;
            header_count_reg <= header_count_next;
            remaining_reg    <= remaining_next;
            mask_key_reg     <= mask_key_next;
            mask_index_reg   <= mask_index_next;
        end
    end

endmodule

[rtl/dfr_queue.sv]
// Small flop-based FIFO of classified entries between parser and emitter.
module dfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dfr_pkg::dfr_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output dfr_pkg::dfr_entry_t head_entry
);

    dfr_pkg::dfr_entry_t mem_reg [dfr_pkg::QDEPTH];

    logic [dfr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dfr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dfr_pkg::QCNT_W-1:0] count_reg,  count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full       = (count_reg == dfr_pkg::QCNT_W'(dfr_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == dfr_pkg::QPTR_W'(dfr_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + dfr_pkg::QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == dfr_pkg::QPTR_W'(dfr_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + dfr_pkg::QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + dfr_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - dfr_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/dfr_emit.sv]
// Result emitter: expands each queue entry into one or two output beats.
module dfr_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  dfr_pkg::dfr_entry_t head_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output dfr_pkg::dfr_out_t   out_data
);

    logic              out_valid_reg, out_valid_next;
    dfr_pkg::dfr_out_t out_reg,       out_next;
    logic              second_reg,    second_next;   // payload of head already sent
    logic              load;

    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        second_next    = second_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (!second_reg && head_entry.pay_valid)
            begin
                out_next.kind         = dfr_pkg::KIND_PAYLOAD;
                out_next.payload_byte = head_entry.pay_byte;
                out_next.is_close     = 1'b0;
                out_next.last         = !head_entry.st_valid;
                pop                   = !head_entry.st_valid;
                second_next           = head_entry.st_valid;
            end
            else
            begin
                out_next.kind         = head_entry.st_kind;
                out_next.payload_byte = 8'h00;
                out_next.is_close     = head_entry.st_close;
                out_next.last         = 1'b1;
                pop                   = 1'b1;
                second_next           = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

[rtl/dfr_checker.sv]
// Port-level checker for the deframer, bound to the top level.
module dfr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input dfr_pkg::dfr_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input dfr_pkg::dfr_out_t out_data
);

    // a waiting input beat stays up with its byte unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while waiting");

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // status beats always close the results of their byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != dfr_pkg::KIND_PAYLOAD) |-> out_data.last)
        else $error("status beat without last");

    // only good status may carry the close flag; status beats carry no byte
    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != dfr_pkg::KIND_PAYLOAD) |->
        (out_data.payload_byte == 8'h00) &&
        (out_data.is_close == 1'b0 || out_data.kind == dfr_pkg::KIND_GOOD))
        else $error("bad status beat fields");

    // a payload beat without last must be followed by its byte's status
    a_pay_then_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=>
        out_valid && (out_data.kind == dfr_pkg::KIND_TRUNC ||
                      out_data.kind == dfr_pkg::KIND_GOOD))
        else $error("payload beat not followed by its status");

endmodule

bind websocket_frame_deframer_top dfr_checker u_dfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
